// File: rtl/core/tsfp_pkg.sv
// ----------------------------------------------------------------------------
// Time-set frame parser package
// Shared types, frame constants and the calendar month-length function.
// ----------------------------------------------------------------------------
package tsfp_pkg;

   localparam logic [7:0]  HDR0         = 8'hA5;
   localparam logic [7:0]  HDR1         = 8'h5A;
   localparam logic [7:0]  PAYLOAD_LEN  = 8'h06;
   localparam logic [3:0]  POS_HUNT     = 4'd0;
   localparam logic [3:0]  POS_HDR1     = 4'd1;
   localparam logic [3:0]  POS_FIRST    = 4'd2;
   localparam logic [3:0]  POS_LAST     = 4'd9;
   localparam int          STORE_DEPTH  = 7;
   localparam logic [11:0] YEAR_BASE    = 12'd2000;
   localparam logic [7:0]  YEAR_OFF_MAX = 8'd99;
   localparam logic [7:0]  HOUR_MAX     = 8'd23;
   localparam logic [7:0]  MINSEC_MAX   = 8'd59;
   localparam logic [7:0]  MONTH_MAX    = 8'd12;

   localparam logic [3:0]  MON_FEB      = 4'd2;
   localparam logic [3:0]  MON_APR      = 4'd4;
   localparam logic [3:0]  MON_JUN      = 4'd6;
   localparam logic [3:0]  MON_SEP      = 4'd9;
   localparam logic [3:0]  MON_NOV      = 4'd11;

   typedef struct packed {
      logic [7:0] length;
      logic [7:0] year_off;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } tsfp_fields_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } tsfp_result_type;

   typedef struct packed {
      logic at_checksum;
      logic frame_ok;
   } tsfp_status_type;

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         MON_FEB: len = leap ? 5'd29 : 5'd28;
         MON_APR: len = 5'd30;
         MON_JUN: len = 5'd30;
         MON_SEP: len = 5'd30;
         MON_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/tsfp_req_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one serial byte per transfer.
// ----------------------------------------------------------------------------
interface tsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/tsfp_rsp_if.sv
// ----------------------------------------------------------------------------
// Date-time result channel
// Valid/ready channel carrying one decoded date and time per transfer.
// ----------------------------------------------------------------------------
interface tsfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;

   modport source (output valid, output year, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface

// File: rtl/core/tsfp_date_check.sv
// ----------------------------------------------------------------------------
// Date and time validator
// Checks the stored frame fields for a legal date in 2000-2099 and a legal time.
// ----------------------------------------------------------------------------
module tsfp_date_check (
   input  tsfp_pkg::tsfp_fields_type fields,
   output logic                      date_ok
);
   import tsfp_pkg::*;

   logic       leap;
   logic [4:0] max_day;

   // Within 2000-2099 the year is a leap year exactly when the offset is a multiple of four.
   assign leap    = (fields.year_off[1:0] == 2'b00);
   assign max_day = month_length(fields.month[3:0], leap);

   assign date_ok = (fields.year_off <= YEAR_OFF_MAX)
                 && (fields.month != 8'd0) && (fields.month <= MONTH_MAX)
                 && (fields.day != 8'd0) && (fields.day <= {3'b000, max_day})
                 && (fields.hour <= HOUR_MAX)
                 && (fields.minute <= MINSEC_MAX)
                 && (fields.second <= MINSEC_MAX);

endmodule

// File: rtl/core/tsfp_frame_tracker.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Holds the byte position, the running checksum and the stored frame fields.
// ----------------------------------------------------------------------------
module tsfp_frame_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   output tsfp_pkg::tsfp_status_type  status,
   output tsfp_pkg::tsfp_result_type  result
);
   import tsfp_pkg::*;

   logic [3:0]      pos_ff, pos_in;
   logic [7:0]      sum_ff, sum_in;
   logic [7:0]      store_ff [STORE_DEPTH];
   logic [2:0]      store_idx;
   logic            store_we;
   logic            date_ok;
   tsfp_fields_type fields;

   assign store_idx = 3'(pos_ff - POS_FIRST);
   assign store_we  = step && (pos_ff >= POS_FIRST) && (pos_ff < POS_LAST);

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (step) begin
         if ((pos_ff == POS_HUNT) || (pos_ff > POS_LAST)) begin
            pos_in = (rx_byte == HDR0) ? POS_HDR1 : POS_HUNT;
            sum_in = (rx_byte == HDR0) ? HDR0 : 8'd0;
         end else if (pos_ff == POS_HDR1) begin
            if (rx_byte == HDR1) begin
               pos_in = POS_FIRST;
               sum_in = sum_ff + rx_byte;
            end else begin
               pos_in = (rx_byte == HDR0) ? POS_HDR1 : POS_HUNT;
               sum_in = (rx_byte == HDR0) ? HDR0 : 8'd0;
            end
         end else if (pos_ff < POS_LAST) begin
            pos_in = pos_ff + 4'd1;
            sum_in = sum_ff + rx_byte;
         end else begin
            pos_in = POS_HUNT;
            sum_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= rx_byte;
      end
   end

   assign fields.length   = store_ff[0];
   assign fields.year_off = store_ff[1];
   assign fields.month    = store_ff[2];
   assign fields.day      = store_ff[3];
   assign fields.hour     = store_ff[4];
   assign fields.minute   = store_ff[5];
   assign fields.second   = store_ff[6];

   tsfp_date_check u_date_check (
      .fields  (fields),
      .date_ok (date_ok)
   );

   assign status.at_checksum = (pos_ff == POS_LAST);
   assign status.frame_ok    = (pos_ff == POS_LAST) && (fields.length == PAYLOAD_LEN)
                            && (sum_ff == rx_byte) && date_ok;

   assign result.year   = YEAR_BASE + {4'b0000, fields.year_off};
   assign result.month  = fields.month[3:0];
   assign result.day    = fields.day[4:0];
   assign result.hour   = fields.hour[4:0];
   assign result.minute = fields.minute[5:0];
   assign result.second = fields.second[5:0];

endmodule

// File: rtl/core/time_set_frame_parser_core.sv
// ----------------------------------------------------------------------------
// Time-set frame parser core
// Hunts for ten-byte time-set frames in a byte stream and delivers each valid
// frame's date and time.
//
//   channel   direction  payload                               transfer when
//   req_chan  in         rx_byte[7:0]                          valid && ready
//   rsp_chan  out        year, month, day, hour, minute, second valid && ready
//
// One byte is taken every cycle unless a stalled result holds back a checksum
// byte; a result is offered once a frame's checksum byte has passed from the
// input register into the result register. Reset clears the byte position,
// the running checksum and both valid flags. A stalled result blocks only the
// next checksum byte, which comes at least ten bytes later, so a result stall
// that ends before that byte arrives never holds back back-to-back input.
// ----------------------------------------------------------------------------
module time_set_frame_parser_core (
   input  logic  clock,
   input  logic  reset,
   tsfp_req_if.sink   req_chan,
   tsfp_rsp_if.source rsp_chan
);
   import tsfp_pkg::*;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   tsfp_result_type out_data_ff;
   logic            advance;
   logic            hit;
   tsfp_status_type status;
   tsfp_result_type result;

   assign advance = in_valid_ff
                 && !(status.at_checksum && out_valid_ff && !rsp_chan.ready);
   assign hit     = advance && status.frame_ok;

   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   tsfp_frame_tracker u_frame_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .status  (status),
      .result  (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (hit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.year   = out_data_ff.year;
   assign rsp_chan.month  = out_data_ff.month;
   assign rsp_chan.day    = out_data_ff.day;
   assign rsp_chan.hour   = out_data_ff.hour;
   assign rsp_chan.minute = out_data_ff.minute;
   assign rsp_chan.second = out_data_ff.second;

`ifndef ASSERT_OFF
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.year >= YEAR_BASE) && (out_data_ff.year <= 12'd2099)
         && (out_data_ff.month != 4'd0) && (out_data_ff.month <= 4'd12)
         && (out_data_ff.day != 5'd0) && (out_data_ff.hour <= 5'd23)
         && (out_data_ff.minute <= 6'd59) && (out_data_ff.second <= 6'd59))
      else $error("result outside the legal date and time range");

   a_result_from_checksum: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && status.at_checksum))
      else $error("result raised without a checksum byte being consumed");

   a_frame_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && status.at_checksum) |=> !status.at_checksum)
      else $error("tracker did not leave the checksum position");
`endif

endmodule
